FILE: src/stereo_linear_resampler_macros.svh
// Assertion macros used by the resampler top level.
`ifndef STEREO_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/srl_pkg.sv
// Package: shared types and constants of the stereo linear resampler.
package srl_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 24;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned MAX_RUN_DEF     = 64;

  // Width of the step ratio register and of the configuration data bus.
  localparam int unsigned STEP_W = 29;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic CFG_STEP_RATIO = 1'b0;
  localparam logic CFG_BYPASS     = 1'b1;

  // What the back end does with a queued frame.
  typedef enum logic [1:0] {
    SRL_KIND_PASS,
    SRL_KIND_PRIME,
    SRL_KIND_INTERP
  } srl_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } srl_bk_state_e;

  // Back end status, observed by the top-level checks.
  typedef struct packed {
    logic busy;
    logic pop;
    logic emit;
    logic emit_last;
    logic phase_below_one;
  } srl_bk_stat_t;

endpackage

FILE: src/srl_in_if.sv
// Interface: input frame channel (valid/ready plus one stereo frame).
interface srl_in_if #(
  parameter int unsigned SAMPLE_BITS = srl_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

FILE: src/srl_out_if.sv
// Interface: result channel (valid/ready plus one output frame).
interface srl_out_if #(
  parameter int unsigned SAMPLE_BITS = srl_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          last_of_run;

  modport source (output valid, output left_out, output right_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input last_of_run,
                  output ready);
endinterface

FILE: src/srl_queue.sv
// Short frame queue between the front and back ends.
module srl_queue #(
  parameter int unsigned DATA_W = 2 * srl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  srl_pkg::srl_kind_e  push_kind_i,
  input  logic [DATA_W-1:0]   push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output srl_pkg::srl_kind_e  pop_kind_o,
  output logic [DATA_W-1:0]   pop_data_o,
  output logic                empty_o
);
  localparam int unsigned PtrW = (srl_pkg::QUEUE_DEPTH > 1) ? $clog2(srl_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(srl_pkg::QUEUE_DEPTH + 1);

  srl_pkg::srl_kind_e kind_q [srl_pkg::QUEUE_DEPTH];
  logic [DATA_W-1:0]  data_q [srl_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == CntW'(srl_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_kind_o = kind_q[rd_ptr_q];
  assign pop_data_o = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(srl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(srl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      kind_q[wr_ptr_q] <= push_kind_i;
      data_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule

FILE: src/srl_front.sv
// Front end: accept input frames and classify them for the back end.
module srl_front #(
  parameter int unsigned SAMPLE_BITS = srl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       bypass_i,
  srl_in_if.sink                     in_frame,
  input  logic                       q_full_i,
  output logic                       push_o,
  output srl_pkg::srl_kind_e         push_kind_o,
  output logic [2*SAMPLE_BITS-1:0]   push_data_o
);
  logic primed_q, primed_d;

  assign in_frame.ready = !q_full_i;
  assign push_o         = in_frame.valid && !q_full_i;
  assign push_data_o    = {in_frame.left_in, in_frame.right_in};

  // Bypass wins; otherwise the first frame only primes the previous-frame store.
  always_comb begin
    if (bypass_i) begin
      push_kind_o = srl_pkg::SRL_KIND_PASS;
    end else if (!primed_q) begin
      push_kind_o = srl_pkg::SRL_KIND_PRIME;
    end else begin
      push_kind_o = srl_pkg::SRL_KIND_INTERP;
    end
  end

  assign primed_d = primed_q || push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else begin
      primed_q <= primed_d;
    end
  end
endmodule

FILE: src/srl_back.sv
// Back end: phase accumulator, interpolation datapath and result register.
module srl_back #(
  parameter int unsigned FRAC_BITS   = srl_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = srl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_RUN     = srl_pkg::MAX_RUN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [srl_pkg::STEP_W-1:0]  step_i,
  input  logic                        q_empty_i,
  input  srl_pkg::srl_kind_e          q_kind_i,
  input  logic [2*SAMPLE_BITS-1:0]    q_data_i,
  output logic                        pop_o,
  srl_out_if.source                   out_result,
  output srl_pkg::srl_bk_stat_t       stat_o
);
  localparam int unsigned S      = SAMPLE_BITS;
  localparam int unsigned PhaseW = ((FRAC_BITS + 1 > srl_pkg::STEP_W) ?
                                    FRAC_BITS + 1 : srl_pkg::STEP_W) + 1;
  localparam int unsigned CntW   = $clog2(MAX_RUN);
  localparam int unsigned ProdW  = S + FRAC_BITS + 2;

  srl_pkg::srl_bk_state_e state_q, state_d;

  logic signed [S-1:0] prev_l_q, prev_r_q, new_l_q, new_r_q;
  logic [PhaseW-1:0]   phase_q;
  logic [CntW-1:0]     cnt_q;
  logic                out_valid_q;
  logic signed [S-1:0] out_l_q, out_r_q;
  logic                out_last_q;

  logic                out_free;
  logic                head_ge_one, sum_ge_one, run_last;
  logic [PhaseW-1:0]   phase_sum;
  logic signed [S-1:0] head_l, head_r, interp_l, interp_r;

  // Control decoded from the state.
  logic pop, emit_pass, emit_run, skip_frame, prime_frame, start_run;

  assign out_free    = !out_valid_q || out_result.ready;
  assign head_l      = q_data_i[2*S-1:S];
  assign head_r      = q_data_i[S-1:0];
  assign head_ge_one = (phase_q[PhaseW-1:FRAC_BITS] != '0);
  assign phase_sum   = phase_q + PhaseW'(step_i);
  assign sum_ge_one  = (phase_sum[PhaseW-1:FRAC_BITS] != '0);
  assign run_last    = sum_ge_one || (cnt_q == CntW'(MAX_RUN - 1));

  // prev + round((new - prev) * phase / 2^FRAC_BITS), ties toward plus infinity.
  function automatic logic signed [S-1:0] lerp(input logic signed [S-1:0] a,
                                               input logic signed [S-1:0] b,
                                               input logic [FRAC_BITS-1:0] frac);
    logic signed [S:0]         diff;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [ProdW-1:0]   prod;
    logic signed [ProdW-1:0]   shifted;
    diff    = (S+1)'(b) - (S+1)'(a);
    frac_s  = {1'b0, frac};
    prod    = diff * frac_s;
    prod    = prod + (ProdW'(1) <<< (FRAC_BITS - 1));
    shifted = prod >>> FRAC_BITS;
    return a + shifted[S-1:0];
  endfunction

  assign interp_l = lerp(prev_l_q, new_l_q, phase_q[FRAC_BITS-1:0]);
  assign interp_r = lerp(prev_r_q, new_r_q, phase_q[FRAC_BITS-1:0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srl_pkg::BK_IDLE: begin
        if (start_run) begin
          state_d = srl_pkg::BK_RUN;
        end
      end
      srl_pkg::BK_RUN: begin
        if (emit_run && run_last) begin
          state_d = srl_pkg::BK_IDLE;
        end
      end
      default: state_d = srl_pkg::BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop         = 1'b0;
    emit_pass   = 1'b0;
    emit_run    = 1'b0;
    skip_frame  = 1'b0;
    prime_frame = 1'b0;
    start_run   = 1'b0;
    case (state_q)
      srl_pkg::BK_IDLE: begin
        pop = !q_empty_i && out_free;
        case (q_kind_i)
          srl_pkg::SRL_KIND_PASS:   emit_pass   = pop;
          srl_pkg::SRL_KIND_PRIME:  prime_frame = pop;
          srl_pkg::SRL_KIND_INTERP: begin
            skip_frame = pop && head_ge_one;
            start_run  = pop && !head_ge_one;
          end
          default: prime_frame = pop;
        endcase
      end
      srl_pkg::BK_RUN: begin
        emit_run = out_free;
      end
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srl_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      cnt_q       <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_free) begin
        out_valid_q <= emit_pass || emit_run;
      end
      if (emit_pass || prime_frame || skip_frame) begin
        prev_l_q <= head_l;
        prev_r_q <= head_r;
      end
      if (skip_frame) begin
        phase_q <= phase_q - (PhaseW'(1) << FRAC_BITS);
      end
      if (start_run) begin
        cnt_q <= '0;
      end
      if (emit_run) begin
        cnt_q <= cnt_q + 1'b1;
        if (!run_last) begin
          phase_q <= phase_sum;
        end else begin
          phase_q  <= sum_ge_one ? phase_sum - (PhaseW'(1) << FRAC_BITS) : '0;
          prev_l_q <= new_l_q;
          prev_r_q <= new_r_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_run) begin
      new_l_q <= head_l;
      new_r_q <= head_r;
    end
    if (emit_pass) begin
      out_l_q    <= head_l;
      out_r_q    <= head_r;
      out_last_q <= 1'b1;
    end else if (emit_run) begin
      out_l_q    <= interp_l;
      out_r_q    <= interp_r;
      out_last_q <= run_last;
    end
  end

  assign out_result.valid       = out_valid_q;
  assign out_result.left_out    = out_l_q;
  assign out_result.right_out   = out_r_q;
  assign out_result.last_of_run = out_last_q;

  assign stat_o.busy            = (state_q == srl_pkg::BK_RUN);
  assign stat_o.pop             = pop;
  assign stat_o.emit            = emit_run;
  assign stat_o.emit_last       = run_last;
  assign stat_o.phase_below_one = !head_ge_one;
endmodule

FILE: src/stereo_linear_resampler.sv
// Top level of the stereo linear-interpolation resampler.
//
//  Port          Dir  Handshake      Carries
//  in_frame      in   valid/ready    left_in, right_in (one stereo frame)
//  out_result    out  valid/ready    left_out, right_out, last_of_run
//  cfg_*_i       in   cfg_we_i only  register index and write data
//
// A frame leaves the queue while the back end is idle; an interpolation frame that
// is not skipped starts a run that emits at most MAX_RUN results, one result per
// cycle while the output register is free. Bypass, priming and skipped frames are
// handled as they are popped and start no run.
// Reset clears the phase, the previous frame, the primed flag and the queue.
// The queue keeps taking frames, until it is full, while the result register stalls downstream.
`include "stereo_linear_resampler_macros.svh"

module stereo_linear_resampler #(
  parameter int unsigned FRAC_BITS   = srl_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = srl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_RUN     = srl_pkg::MAX_RUN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  srl_in_if.sink                      in_frame,
  srl_out_if.source                   out_result,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [srl_pkg::STEP_W-1:0]  cfg_wdata_i
);
  // Step ratio of 1.0 at reset, saturated if 1.0 does not fit the register.
  localparam logic [srl_pkg::STEP_W-1:0] StepOne =
    (FRAC_BITS < srl_pkg::STEP_W) ? (srl_pkg::STEP_W'(1) << FRAC_BITS) : '1;

  logic [srl_pkg::STEP_W-1:0] step_q;
  logic                       bypass_q;

  logic                       q_full, q_empty, q_push, q_pop;
  srl_pkg::srl_kind_e         push_kind, pop_kind;
  logic [2*SAMPLE_BITS-1:0]   push_data, pop_data;
  srl_pkg::srl_bk_stat_t      bk_stat;

  // Configuration registers; the user writes them only while the block is idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= StepOne;
      bypass_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        srl_pkg::CFG_STEP_RATIO: step_q   <= cfg_wdata_i;
        srl_pkg::CFG_BYPASS:     bypass_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Front: accept each transaction, tag it as pass, prime or interpolate.
  srl_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bypass_i    (bypass_q),
    .in_frame    (in_frame),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_kind_o (push_kind),
    .push_data_o (push_data)
  );

  // Queue: decouple input acceptance from the run in progress.
  srl_queue #(
    .DATA_W (2 * SAMPLE_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_kind_i (push_kind),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_kind_o  (pop_kind),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  // Back: advance the phase, interpolate, and hold results until taken.
  srl_back #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RUN     (MAX_RUN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step_q),
    .q_empty_i  (q_empty),
    .q_kind_i   (pop_kind),
    .q_data_i   (pop_data),
    .pop_o      (q_pop),
    .out_result (out_result),
    .stat_o     (bk_stat)
  );

  // The back end never pops an empty queue.
  `SRL_ASSERT_NOW(a_pop_not_empty, bk_stat.pop, !q_empty, "pop from empty queue")
  // Inside a run the phase stays below one.
  `SRL_ASSERT_NOW(a_run_phase, bk_stat.busy, bk_stat.phase_below_one, "run phase at or above one")
  // The last result of a run returns the back end to idle.
  `SRL_ASSERT_NEXT(a_run_ends, bk_stat.emit && bk_stat.emit_last, !bk_stat.busy, "run did not end")
  // A run result always lands in the output register.
  `SRL_ASSERT_NEXT(a_emit_valid, bk_stat.emit, out_result.valid, "run result lost")

endmodule

FILE: dv/tb_top.sv
// Testbench for stereo_linear_resampler: directed table then random phases, scoreboard check.
module tb_top;

  localparam int     FRAC          = srl_pkg::FRAC_BITS_DEF;
  localparam int     SB            = srl_pkg::SAMPLE_BITS_DEF;
  localparam int     RUN_MAX       = srl_pkg::MAX_RUN_DEF;
  localparam int     STEP_W        = srl_pkg::STEP_W;
  localparam logic   CFG_STEP_RATIO = srl_pkg::CFG_STEP_RATIO;
  localparam logic   CFG_BYPASS     = srl_pkg::CFG_BYPASS;
  localparam longint PHASE_ONE     = longint'(1) << FRAC;
  localparam int     SETTLE_CYCLES = (srl_pkg::QUEUE_DEPTH + 2) * (RUN_MAX + 1);
  localparam int     NUM_ROWS      = 26;

  // Random step bounds 1/64 and 16.0, and unity (input rate equals output rate).
  localparam logic [STEP_W-1:0] STEP_MIN  = 29'd262144;
  localparam logic [STEP_W-1:0] STEP_MAX  = 29'd268435456;
  localparam logic [STEP_W-1:0] STEP_UNIT = 29'd16777216;

  typedef logic signed [SB-1:0] sample_t;

  // One output transaction as the block should deliver it.
  typedef struct {
    sample_t left;
    sample_t right;
    logic    last;
  } out_frame_t;

  typedef enum logic {
    ROW_CFG,
    ROW_FRAME
  } row_kind_e;

  // One row of the directed table: either a register write or a frame.
  // Rows with typed set carry their expected result inline (pass-through rows).
  typedef struct packed {
    row_kind_e         kind;
    logic              cfg_idx;
    logic [STEP_W-1:0] cfg_val;
    logic [SB-1:0]     left;
    logic [SB-1:0]     right;
    logic              typed;
    logic [SB-1:0]     exp_left;
    logic [SB-1:0]     exp_right;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic              cfg_we;
  logic              cfg_index;
  logic [STEP_W-1:0] cfg_wdata;

  srl_in_if  in_ch ();
  srl_out_if out_ch ();

  stereo_linear_resampler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_frame    (in_ch),
    .out_result  (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Resampler model state, updated once per accepted input transaction.
  // ---------------------------------------------------------------------------
  sample_t    hist_left;
  sample_t    hist_right;
  bit         hist_valid;
  longint     read_pos;
  longint     step_cfg;
  bit         bypass_cfg;
  out_frame_t run_buf [RUN_MAX];

  out_frame_t pending_outputs [$];
  int         mismatch_count;
  int         burst_left;

  // prev + round((new - prev) * frac), ties rounded toward plus infinity.
  function automatic sample_t blend(sample_t a, sample_t b, longint frac);
    longint span;
    span = (longint'(b) - longint'(a)) * frac + (PHASE_ONE >>> 1);
    return sample_t'(longint'(a) + (span >>> FRAC));
  endfunction

  // Fill run_buf with the outputs one input frame causes; return how many.
  function automatic int resample_frame(sample_t l, sample_t r);
    int n;
    n = 0;
    if (bypass_cfg) begin
      run_buf[0] = '{left: l, right: r, last: 1'b1};
      hist_left  = l;
      hist_right = r;
      hist_valid = 1'b1;
      return 1;
    end
    // First frame after reset only loads the history.
    if (!hist_valid) begin
      hist_left  = l;
      hist_right = r;
      hist_valid = 1'b1;
      return 0;
    end
    while (read_pos < PHASE_ONE && n < RUN_MAX) begin
      run_buf[n] = '{left:  blend(hist_left, l, read_pos),
                     right: blend(hist_right, r, read_pos),
                     last:  1'b0};
      read_pos += step_cfg;
      n++;
    end
    if (n > 0) run_buf[n-1].last = 1'b1;
    // Phase past one skips the frame; a run cut short by the limit restarts at zero.
    if (read_pos >= PHASE_ONE) begin
      read_pos -= PHASE_ONE;
    end else begin
      read_pos = 0;
    end
    hist_left  = l;
    hist_right = r;
    return n;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver side.
  // ---------------------------------------------------------------------------

  // Drive one frame, hold it until the transaction happens, then queue its outputs.
  task automatic send_frame(input sample_t l, input sample_t r, input bit typed,
                            input out_frame_t typed_res);
    int gap;
    int n;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      // Mostly short bursts, now and then a long stretch with no gaps.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    n = resample_frame(l, r);
    if (typed) begin
      pending_outputs = {pending_outputs, typed_res};
    end else begin
      for (int i = 0; i < n; i++) pending_outputs = {pending_outputs, run_buf[i]};
    end
  endtask

  // Drop valid, wait for every queued output, then let frames with no output finish.
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; call only while the block is idle.
  task automatic write_reg(input logic idx, input logic [STEP_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_STEP_RATIO) begin
      step_cfg = longint'(val);
    end else begin
      bypass_cfg = val[0];
    end
  endtask

  function automatic sample_t rand_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return sample_t'(16'h7FFF);
        1:       return sample_t'(16'h8000);
        2:       return sample_t'(16'h0000);
        default: return sample_t'(16'hFFFF);
      endcase
    end
    return sample_t'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Starts in pass-through (reset state), so clear bypass first
  // to see the priming frame; unity step is still the reset value there.
  // ---------------------------------------------------------------------------
  row_t script [NUM_ROWS] = '{
    '{ROW_CFG,   CFG_BYPASS,     29'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    // priming frame: loads history, no output
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0064, 16'hFF9C, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    // half step: ties at the midpoint round up
    '{ROW_CFG,   CFG_STEP_RATIO, 29'h0800000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    // smallest step: a full run of the maximum length
    '{ROW_CFG,   CFG_STEP_RATIO, STEP_MIN,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    // zero step: run limit cuts the run, phase restarts at zero
    '{ROW_CFG,   CFG_STEP_RATIO, 29'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    // step of three: frames skipped in between
    '{ROW_CFG,   CFG_STEP_RATIO, 29'h3000000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h03E8, 16'hFC18, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0001, 16'h0002, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0003, 16'h0004, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    // largest step
    '{ROW_CFG,   CFG_STEP_RATIO, STEP_MAX,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0005, 16'h0005, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    // pass-through: each frame comes back unchanged as the last of its run
    '{ROW_CFG,   CFG_BYPASS,     29'd1,     16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
    '{ROW_FRAME, CFG_STEP_RATIO, 29'd0,     16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, 16'h0000},
    '{ROW_CFG,   CFG_STEP_RATIO, STEP_UNIT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000}
  };

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a rotating 16-bit mask, reloaded after a random hold count.
  // Bit 0 is always set, so a stall never outlasts one rotation of the mask.
  // ---------------------------------------------------------------------------
  initial begin : ready_pattern
    logic [15:0] mask;
    int          hold_cnt;
    out_ch.ready = 1'b0;
    mask         = '1;
    hold_cnt     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt == 0) begin
        hold_cnt = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       mask = '1;
          1:       mask = 16'($urandom) | 16'h0001;
          2:       mask = 16'($urandom & $urandom) | 16'h0001;
          default: mask = 16'h0001;
        endcase
      end
      hold_cnt--;
      out_ch.ready <= mask[0];
      mask = {mask[0], mask[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: compare every output transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    out_frame_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected output L=%0d R=%0d last=%0b",
                                  out_ch.left_out, out_ch.right_out, out_ch.last_of_run));
      end else begin
        want = pending_outputs.pop_front();
        if (out_ch.left_out !== want.left)
          report_mismatch($sformatf("left_out %0d, want %0d", out_ch.left_out, want.left));
        if (out_ch.right_out !== want.right)
          report_mismatch($sformatf("right_out %0d, want %0d", out_ch.right_out, want.right));
        if (out_ch.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b",
                                    out_ch.last_of_run, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t              row;
    out_frame_t        typed_res;
    out_frame_t        no_res;
    logic [STEP_W-1:0] new_step;

    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_STEP_RATIO;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    hist_left      = '0;
    hist_right     = '0;
    hist_valid     = 1'b0;
    read_pos       = 0;
    step_cfg       = longint'(STEP_UNIT);
    bypass_cfg     = 1'b1;
    mismatch_count = 0;
    burst_left     = 0;
    no_res         = '{left: '0, right: '0, last: 1'b0};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Give the block room for any clearing it does after reset.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        typed_res = '{left:  sample_t'(row.exp_left),
                      right: sample_t'(row.exp_right),
                      last:  1'b1};
        send_frame(sample_t'(row.left), sample_t'(row.right), row.typed, typed_res);
      end
    end

    // Random phases, each with its own step; the extremes come first and one
    // phase runs in pass-through.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0:       new_step = STEP_MIN;
        1:       new_step = STEP_MAX;
        2:       new_step = STEP_W'($urandom_range(32'h0400000, 32'h2000000));
        default: new_step = STEP_W'($urandom_range(STEP_MIN, STEP_MAX));
      endcase
      write_reg(CFG_STEP_RATIO, new_step);
      write_reg(CFG_BYPASS, STEP_W'(ph == 4));
      for (int k = 0; k < 25; k++) begin
        // Hold the sender once mid-phase until the block has caught up.
        if (ph == 2 && k == 12) begin
          @(negedge clk_i);
          in_ch.valid <= 1'b0;
          burst_left = 0;
          while (pending_outputs.size() != 0) @(posedge clk_i);
        end
        send_frame(rand_sample(), rand_sample(), 1'b0, no_res);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every output behind a long stall).
  initial begin : watchdog
    #10000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
